[rtl/atm_pkg.sv]
// shared types and constants for the ack timeout matcher
`timescale 1ns / 1ps

package atm_pkg;

    // command codes
    localparam logic [1:0] CMD_DATA   = 2'd0;
    localparam logic [1:0] CMD_ACK    = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // frame types
    localparam logic [3:0] TYPE_DATA = 4'd1;
    localparam logic [3:0] TYPE_ACK  = 4'd2;

    // event codes
    localparam logic EV_ACK    = 1'b0;
    localparam logic EV_EXPIRE = 1'b1;

    // field widths
    localparam int ADDR_W  = 16;
    localparam int TIMER_W = 24;

    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = TIMER_W'(1000);
    localparam logic [TIMER_W-1:0] ELAPSED_MAX   = {TIMER_W{1'b1}};

    // one emitted record
    typedef struct packed {
        logic              event_res;
        logic [3:0]        frm_kind;
        logic [ADDR_W-1:0] dest_addr;
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] frm_seq;
    } t_result;

endpackage

[rtl/atm_core.sv]
// timer state, ack matching and expiry decision
`timescale 1ns / 1ps

module atm_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [1:0]                     i_cmd,
    input  logic [3:0]                     i_frm_kind,
    input  logic [atm_pkg::ADDR_W-1:0]     i_dest_addr,
    input  logic [atm_pkg::ADDR_W-1:0]     i_src_addr,
    input  logic [atm_pkg::ADDR_W-1:0]     i_frm_seq,
    input  logic [atm_pkg::TIMER_W-1:0]    i_timeout,
    output logic                           o_res_valid,
    output atm_pkg::t_result               o_res
);

    logic                        r_armed;
    logic                        n_armed;
    logic [atm_pkg::ADDR_W-1:0]  r_wait_dest;
    logic [atm_pkg::ADDR_W-1:0]  n_wait_dest;
    logic [atm_pkg::ADDR_W-1:0]  r_wait_src;
    logic [atm_pkg::ADDR_W-1:0]  n_wait_src;
    logic [atm_pkg::ADDR_W-1:0]  r_wait_index;
    logic [atm_pkg::ADDR_W-1:0]  n_wait_index;
    logic [atm_pkg::TIMER_W-1:0] r_elapsed;
    logic [atm_pkg::TIMER_W-1:0] n_elapsed;
    logic [atm_pkg::TIMER_W-1:0] w_elapsed_inc;
    logic                        w_match;

    // saturating tick count
    assign w_elapsed_inc = (r_elapsed == atm_pkg::ELAPSED_MAX) ? r_elapsed
                                                               : r_elapsed + 1'b1;

    // ack must mirror the waiting data frame
    assign w_match = (i_frm_kind == atm_pkg::TYPE_ACK) &&
                     (i_dest_addr == r_wait_src) &&
                     (i_src_addr == r_wait_dest) &&
                     (i_frm_seq == r_wait_index);

    // command decode and next state
    always_comb begin
        n_armed      = r_armed;
        n_wait_dest  = r_wait_dest;
        n_wait_src   = r_wait_src;
        n_wait_index = r_wait_index;
        n_elapsed    = r_elapsed;
        o_res_valid  = 1'b0;
        o_res        = '0;
        if (i_accept) begin
            unique case (i_cmd)
                atm_pkg::CMD_DATA: begin
                    if (!r_armed && i_frm_kind == atm_pkg::TYPE_DATA) begin
                        n_armed      = 1'b1;
                        n_wait_dest  = i_dest_addr;
                        n_wait_src   = i_src_addr;
                        n_wait_index = i_frm_seq;
                        n_elapsed    = '0;
                    end
                end
                atm_pkg::CMD_ACK: begin
                    if (r_armed && w_match) begin
                        n_armed         = 1'b0;
                        o_res_valid     = 1'b1;
                        o_res.event_res = atm_pkg::EV_ACK;
                        o_res.frm_kind  = atm_pkg::TYPE_ACK;
                        o_res.dest_addr = i_dest_addr;
                        o_res.src_addr  = i_src_addr;
                        o_res.frm_seq   = i_frm_seq;
                    end
                end
                atm_pkg::CMD_TICK: begin
                    if (r_armed) begin
                        n_elapsed = w_elapsed_inc;
                        if (w_elapsed_inc >= i_timeout) begin
                            n_armed         = 1'b0;
                            o_res_valid     = 1'b1;
                            o_res.event_res = atm_pkg::EV_EXPIRE;
                            o_res.frm_kind  = atm_pkg::TYPE_DATA;
                            o_res.dest_addr = r_wait_dest;
                            o_res.src_addr  = r_wait_src;
                            o_res.frm_seq   = r_wait_index;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // armed flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
        end else begin
            r_armed <= n_armed;
        end
    end

    // stored frame and count, only read while armed
    always_ff @(posedge i_clk) begin
        r_wait_dest  <= n_wait_dest;
        r_wait_src   <= n_wait_src;
        r_wait_index <= n_wait_index;
        r_elapsed    <= n_elapsed;
    end

endmodule

[rtl/atm_obuf.sv]
// output register with one skid entry
`timescale 1ns / 1ps

module atm_obuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_res_valid,
    input  atm_pkg::t_result i_res,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output atm_pkg::t_result o_res,
    output logic             o_in_ready,
    output logic             o_skid_valid
);

    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_skid_valid;
    logic             n_skid_valid;
    atm_pkg::t_result r_out;
    atm_pkg::t_result n_out;
    atm_pkg::t_result r_skid;
    atm_pkg::t_result n_skid;

    // refill output from skid first, else from the new word
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = i_res_valid;
                if (i_res_valid) begin
                    n_out = i_res;
                end
            end
        end else if (i_res_valid) begin
            n_skid       = i_res;
            n_skid_valid = 1'b1;
        end
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid  = r_out_valid;
    assign o_res        = r_out;
    assign o_in_ready   = !r_skid_valid;
    assign o_skid_valid = r_skid_valid;

endmodule

[rtl/ack_timeout_matcher_top.sv]
// Ack timeout matcher for a stop-and-wait link. A data word (cmd 0, frame type 1) arms the
// timer when idle and stores its addresses and index; an ack word (cmd 1, frame type 2) whose
// addresses mirror the stored ones and whose index matches disarms it and is forwarded with
// event 0; each tick word (cmd 2) while armed advances a saturating count, and when the count
// reaches the timeout register the stored data record is emitted with event 1. A timeout of
// zero expires on the first tick. One word is taken per clock while input ready is high; a result
// is registered in the output register, or parked in the skid entry while the output stalls. The
// output has a register and one skid entry, so input ready drops only when both are full.
// The timeout register (reset 1000) is written with i_cfg_we and should change only when idle.
`timescale 1ns / 1ps

module ack_timeout_matcher_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [atm_pkg::TIMER_W-1:0] i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_cmd,
    input  logic [3:0]                  i_frm_kind,
    input  logic [atm_pkg::ADDR_W-1:0]  i_dest_addr,
    input  logic [atm_pkg::ADDR_W-1:0]  i_src_addr,
    input  logic [atm_pkg::ADDR_W-1:0]  i_frm_seq,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_event_res,
    output logic [3:0]                  o_out_frm_kind,
    output logic [atm_pkg::ADDR_W-1:0]  o_out_dest_addr,
    output logic [atm_pkg::ADDR_W-1:0]  o_out_src_addr,
    output logic [atm_pkg::ADDR_W-1:0]  o_out_frm_seq
);

    logic [atm_pkg::TIMER_W-1:0] r_timeout;
    logic                        w_accept;
    logic                        w_res_valid;
    atm_pkg::t_result            w_res;
    atm_pkg::t_result            w_out;
    logic                        w_skid_valid;

    // timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= atm_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    assign w_accept = i_in_valid && o_in_ready;

    // matcher and timer
    atm_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_cmd        (i_cmd),
        .i_frm_kind   (i_frm_kind),
        .i_dest_addr  (i_dest_addr),
        .i_src_addr   (i_src_addr),
        .i_frm_seq    (i_frm_seq),
        .i_timeout    (r_timeout),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res)
    );

    // result register and skid
    atm_obuf u_obuf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_res_valid  (w_res_valid),
        .i_res        (w_res),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_res        (w_out),
        .o_in_ready   (o_in_ready),
        .o_skid_valid (w_skid_valid)
    );

    assign o_event_res     = w_out.event_res;
    assign o_out_frm_kind  = w_out.frm_kind;
    assign o_out_dest_addr = w_out.dest_addr;
    assign o_out_src_addr  = w_out.src_addr;
    assign o_out_frm_seq   = w_out.frm_seq;

`ifndef SYNTH
    // skid only holds a word behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_skid_valid |-> o_out_valid)
        else $error("skid entry valid while output register empty");

    // results only come from accepted words
    a_res_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> w_accept)
        else $error("result produced without an accepted word");

    // a result arriving at a stalled output is parked in the skid
    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && o_out_valid && !i_out_ready) |=> w_skid_valid)
        else $error("result lost behind a stalled output");
`endif

endmodule
